// ----- rtl/core/floyd_steinberg_dither_defines.svh -----
// Assertion macros for the dither core.
`ifndef FLOYD_STEINBERG_DITHER_DEFINES_SVH
`define FLOYD_STEINBERG_DITHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fsd_pkg.sv -----
// Types and constants shared by the dither core.
package fsd_pkg;

    localparam int ERR_W = 12;
    localparam int PIX_W = 8;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [11:0] WIDTH_RST  = 12'd640;
    localparam logic [11:0] HEIGHT_RST = 12'd480;
    localparam logic [7:0]  THRESH_RST = 8'd128;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_in;

    typedef struct packed {
        logic dithered_bit;
        logic frame_end;
    } t_pix_out;

    typedef struct packed {
        logic                    valid;
        logic [PIX_W-1:0]        pixel;
        logic                    frame_start;
        logic                    last_col;
        logic signed [ERR_W-1:0] above;
        logic [7:0]              threshold;
    } t_dif_req;

    typedef struct packed {
        logic                    white;
        logic signed [ERR_W-1:0] row_err;
        logic signed [ERR_W-1:0] near_next;
    } t_dif_rsp;

endpackage

// ----- rtl/core/fsd_diffuse.sv -----
// Quantizer and error split with the right-carry and next-row partial sums.
module fsd_diffuse
    import fsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dif_req i_req,
    output t_dif_rsp o_rsp
);

    logic signed [ERR_W-1:0] r_carry, r_near, r_far;
    logic signed [ERR_W-1:0] carry_cur, near_cur, far_cur;
    logic signed [ERR_W-1:0] stage_a, work, s7, s3, s5, s1;
    logic signed [13:0]      sum_a, sum_b, sum_row, sum_near;
    logic signed [12:0]      err;
    logic signed [15:0]      e16;
    logic                    white;

    function automatic logic signed [ERR_W-1:0] sat12(input logic signed [13:0] v);
        if (v > 14'sd2047) begin
            return 12'sh7FF;
        end else if (v < -14'sd2048) begin
            return 12'sh800;
        end else begin
            return v[ERR_W-1:0];
        end
    endfunction

    // divide by 16, truncating toward zero
    function automatic logic signed [ERR_W-1:0] div16(input logic signed [15:0] v);
        logic signed [15:0] t;
        t = v + (v[15] ? 16'sd15 : 16'sd0);
        return $signed(t[15:4]);
    endfunction

    always_comb begin
        carry_cur = i_req.frame_start ? '0 : r_carry;
        near_cur  = i_req.frame_start ? '0 : r_near;
        far_cur   = i_req.frame_start ? '0 : r_far;

        sum_a   = $signed({6'b0, i_req.pixel}) + $signed({{2{carry_cur[11]}}, carry_cur});
        stage_a = sat12(sum_a);
        sum_b   = $signed({{2{stage_a[11]}}, stage_a})
                + $signed({{2{i_req.above[11]}}, i_req.above});
        work    = sat12(sum_b);
        white   = $signed({work[11], work}) > $signed({5'b0, i_req.threshold});
        err     = $signed({work[11], work}) - (white ? 13'sd255 : 13'sd0);

        e16 = $signed({{3{err[12]}}, err});
        s7  = div16((e16 <<< 3) - e16);
        s3  = div16((e16 <<< 1) + e16);
        s5  = div16((e16 <<< 2) + e16);
        s1  = div16(e16);

        sum_row  = $signed({{2{near_cur[11]}}, near_cur}) + $signed({{2{s3[11]}}, s3});
        sum_near = $signed({{2{far_cur[11]}}, far_cur}) + $signed({{2{s5[11]}}, s5});

        o_rsp.white     = white;
        o_rsp.row_err   = sat12(sum_row);
        o_rsp.near_next = sat12(sum_near);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_near  <= '0;
            r_far   <= '0;
        end else if (i_req.valid) begin
            if (i_req.last_col) begin
                r_carry <= '0;
                r_near  <= '0;
                r_far   <= '0;
            end else begin
                r_carry <= sat12($signed({{2{s7[11]}}, s7}));
                r_near  <= o_rsp.near_next;
                r_far   <= s1;
            end
        end
    end

endmodule

// ----- rtl/core/floyd_steinberg_dither.sv -----
// Floyd-Steinberg error-diffusion dither, top level with row-error memory.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+--------------------------------
//  in      | in  | i_in_valid / o_in_stall | i_in  (pixel, frame_start)
//  out     | out | o_out_valid/ i_out_stall| o_out (dithered_bit, frame_end)
//  cfg     | in  | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One pixel per clock while o_in_stall is low; a request passes the s1
// registers into the result queue. The rate is set by the right-carry loop
// in fsd_diffuse and the single row-memory write port (a second write at
// the row end is deferred). Synchronous reset clears position, line state
// and queues; the row memory is not cleared, as the first row never reads it.
// Output stall backs up through a two-entry result queue into o_in_stall.
`include "floyd_steinberg_dither_defines.svh"

module floyd_steinberg_dither
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_in     i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pix_out    o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [11:0] r_width, r_height;
    logic [7:0]  r_thresh;

    logic [XW-1:0] r_col, n_col, cur_x;
    logic [YW-1:0] r_row, n_row, cur_y;
    logic [13:0]   w_eff, h_eff;
    logic          last_col, last_row, accept;

    logic                    r_s1_v, r_s1_fs, r_s1_last_col, r_s1_row_nz, r_s1_fend;
    logic [PIX_W-1:0]        r_s1_pix;
    logic [XW-1:0]           r_s1_x;

    logic [ERR_W-1:0] r_mem [MAX_WIDTH];
    logic [ERR_W-1:0] r_rd_data, r_fwd_d, n_fwd_d;
    logic             r_fwd_v, n_fwd_v;

    logic             wr_s1, wr_en, pend_set, pend_flush;
    logic [XW-1:0]    wr_addr;
    logic [ERR_W-1:0] wr_data;
    logic             r_pend_v, n_pend_v;
    logic [XW-1:0]    r_pend_a, n_pend_a;
    logic [ERR_W-1:0] r_pend_d, n_pend_d;

    t_dif_req dif_req;
    t_dif_rsp dif_rsp;

    t_pix_out   r_q [2];
    logic       r_wp, r_rp, pop;
    logic [1:0] r_cnt;
    logic [2:0] occ_next;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:     r_width  <= i_cfg_data;
                CFG_HEIGHT:    r_height <= i_cfg_data;
                CFG_THRESHOLD: r_thresh <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // position, worked out at acceptance
    always_comb begin
        w_eff = (r_width == '0) ? 14'd1 :
                ({2'b0, r_width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {2'b0, r_width};
        h_eff = (r_height == '0) ? 14'd1 :
                ({2'b0, r_height} > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : {2'b0, r_height};
        cur_x    = i_in.frame_start ? '0 : r_col;
        cur_y    = i_in.frame_start ? '0 : r_row;
        last_col = 14'(cur_x) >= (w_eff - 14'd1);
        last_row = 14'(cur_y) >= (h_eff - 14'd1);
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : YW'(cur_y + 1'b1);
        end else begin
            n_col = XW'(cur_x + 1'b1);
            n_row = cur_y;
        end
    end

    assign occ_next   = 3'(r_cnt) + 3'(r_s1_v) - 3'(pop);
    assign o_in_stall = occ_next >= 3'd2;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_in.pixel;
            r_s1_fs       <= i_in.frame_start;
            r_s1_x        <= cur_x;
            r_s1_last_col <= last_col;
            r_s1_row_nz   <= cur_y != '0;
            r_s1_fend     <= last_col && last_row;
        end
    end

    // diffusion
    always_comb begin
        dif_req.valid       = r_s1_v;
        dif_req.pixel       = r_s1_pix;
        dif_req.frame_start = r_s1_fs;
        dif_req.last_col    = r_s1_last_col;
        dif_req.above       = !r_s1_row_nz ? '0 :
                              r_fwd_v ? $signed(r_fwd_d) : $signed(r_rd_data);
        dif_req.threshold   = r_thresh;
    end

    fsd_diffuse u_diffuse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dif_req),
        .o_rsp   (dif_rsp)
    );

    // row memory writes: column x-1 if x>0; column x at row end, deferred if x>0
    always_comb begin
        wr_s1      = r_s1_v && ((r_s1_x != '0) || r_s1_last_col);
        pend_set   = r_s1_v && r_s1_last_col && (r_s1_x != '0);
        pend_flush = r_pend_v && !wr_s1;
        wr_en      = wr_s1 || pend_flush;
        if (wr_s1) begin
            wr_addr = (r_s1_x != '0) ? XW'(r_s1_x - 1'b1) : r_s1_x;
            wr_data = (r_s1_x != '0) ? dif_rsp.row_err : dif_rsp.near_next;
        end else begin
            wr_addr = r_pend_a;
            wr_data = r_pend_d;
        end
        n_pend_v = pend_set || (r_pend_v && !pend_flush);
        n_pend_a = pend_set ? r_s1_x : r_pend_a;
        n_pend_d = pend_set ? dif_rsp.near_next : r_pend_d;
        if (wr_en && wr_addr == cur_x) begin
            n_fwd_v = 1'b1;
            n_fwd_d = wr_data;
        end else if (n_pend_v && n_pend_a == cur_x) begin
            n_fwd_v = 1'b1;
            n_fwd_d = n_pend_d;
        end else begin
            n_fwd_v = 1'b0;
            n_fwd_d = wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[cur_x];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_fwd_v  <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_fwd_v  <= n_fwd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_a <= n_pend_a;
        r_pend_d <= n_pend_d;
        r_fwd_d  <= n_fwd_d;
    end

    // result queue
    assign o_out_valid = r_cnt != '0;
    assign o_out       = r_q[r_rp];
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (r_s1_v) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(occ_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_q[r_wp].dithered_bit <= dif_rsp.white;
            r_q[r_wp].frame_end    <= r_s1_fend;
        end
    end

    `FSD_ASSERT_NOW(a_queue_room, r_s1_v, (r_cnt < 2'd2) || pop, "result queue overflow")
    `FSD_ASSERT_NOW(a_pend_free, pend_set, !r_pend_v, "deferred row write overwritten")
    `FSD_ASSERT_NEXT(a_accept_s1, accept, r_s1_v, "accepted request lost before compute")
    `FSD_ASSERT_NOW(a_fend_last, r_s1_v && r_s1_fend, r_s1_last_col, "frame end off row end")

endmodule
